// ===== src/kvt_pkg.sv =====
// Shared types, constants and arithmetic helpers of the keyframe vertex transform.
package kvt_pkg;

  // Coordinate word width (Q8.8 at 16 bits); the payload structs follow from it
  localparam int COORD_WIDTH = 16;
  localparam int UV_WIDTH    = 15;
  localparam int Q_WIDTH     = 16;

  localparam logic [UV_WIDTH-1:0] UV_ONE = UV_WIDTH'(16384);

  // Datapath widths, sized from the worst-case magnitudes of each step
  localparam int SCALED_W = COORD_WIDTH + 4;
  localparam int ROT_W    = COORD_WIDTH + 8;
  localparam int NODE_W   = (COORD_WIDTH + 13 < 41) ? COORD_WIDTH + 13 : 41;

  // Pipeline depth: seven lane stages plus the output register
  localparam int LANE_STAGES = 7;
  localparam int NUM_STAGES  = LANE_STAGES + 1;

  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  localparam logic signed [63:0] WIDE_LIM  = 64'sd1099511627775;
  localparam logic signed [63:0] ROUND_ADD = 64'sd2048;

  typedef enum logic [2:0] {
    REG_NODE_ROW_0,
    REG_NODE_ROW_1,
    REG_NODE_ROW_2,
    REG_ROTATION,
    REG_SCALE,
    REG_TRANSLATION
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][63:0] node_row;
    logic [63:0]      rotation;
    logic [47:0]      scale;
    logic [47:0]      translation;
  } cfg_t;

  typedef logic [2:0][2:0][Q_WIDTH-1:0] rot_t;
  typedef logic [2:0][COORD_WIDTH-1:0]  vec_t;
  typedef logic [2:0][NODE_W-1:0]       lane_out_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;
    logic signed [COORD_WIDTH-1:0] normal_x;
    logic signed [COORD_WIDTH-1:0] normal_y;
    logic signed [COORD_WIDTH-1:0] normal_z;
    logic [UV_WIDTH-1:0]           tex_u;
    logic [UV_WIDTH-1:0]           tex_v;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_pos_x;
    logic signed [COORD_WIDTH-1:0] out_pos_y;
    logic signed [COORD_WIDTH-1:0] out_pos_z;
    logic signed [COORD_WIDTH-1:0] out_norm_x;
    logic signed [COORD_WIDTH-1:0] out_norm_y;
    logic signed [COORD_WIDTH-1:0] out_norm_z;
    logic [UV_WIDTH-1:0]           out_u;
    logic [UV_WIDTH-1:0]           out_v;
  } out_item_t;

  // Round half up by 12 fraction bits
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x);
    return (x + ROUND_ADD) >>> 12;
  endfunction

  function automatic logic signed [63:0] clamp_wide(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > WIDE_LIM) r = WIDE_LIM;
    else if (x < -WIDE_LIM) r = -WIDE_LIM;
    else r = x;
    return r;
  endfunction

  function automatic logic [Q_WIDTH-1:0] sat_q(input logic signed [63:0] x);
    logic [Q_WIDTH-1:0] r;
    if (x > 64'sd32767) r = Q_WIDTH'(16'h7fff);
    else if (x < -64'sd32768) r = Q_WIDTH'(16'h8000);
    else r = x[Q_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [63:0] x);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic [COORD_WIDTH-1:0] r;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (x > hi) r = hi[COORD_WIDTH-1:0];
    else if (x < lo) r = lo[COORD_WIDTH-1:0];
    else r = x[COORD_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic [UV_WIDTH-1:0] one_minus(input logic [UV_WIDTH-1:0] t);
    logic [UV_WIDTH-1:0] r;
    if (t > UV_ONE) r = '0;
    else r = UV_ONE - t;
    return r;
  endfunction

endpackage

// ===== src/kvt_regs.sv =====
// APB-style register file holding node matrix and keyframe configuration.
module kvt_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kvt_pkg::ADDR_W-1:0] paddr,
  input  logic [kvt_pkg::DATA_W-1:0] pwdata,
  output logic [kvt_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output kvt_pkg::cfg_t              cfg_o
);

  kvt_pkg::cfg_t     cfg_q;
  kvt_pkg::reg_idx_e idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = kvt_pkg::reg_idx_e'(paddr[5:3]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_row[0]  <= 64'h0000_0000_0000_1000;
      cfg_q.node_row[1]  <= 64'h0000_0000_1000_0000;
      cfg_q.node_row[2]  <= 64'h0000_1000_0000_0000;
      cfg_q.rotation     <= 64'h0000_0000_0000_1000;
      cfg_q.scale        <= 48'h1000_1000_1000;
      cfg_q.translation  <= '0;
    end else if (wr) begin
      unique case (idx)
        kvt_pkg::REG_NODE_ROW_0:  cfg_q.node_row[0] <= pwdata;
        kvt_pkg::REG_NODE_ROW_1:  cfg_q.node_row[1] <= pwdata;
        kvt_pkg::REG_NODE_ROW_2:  cfg_q.node_row[2] <= pwdata;
        kvt_pkg::REG_ROTATION:    cfg_q.rotation    <= pwdata;
        kvt_pkg::REG_SCALE:       cfg_q.scale       <= pwdata[47:0];
        kvt_pkg::REG_TRANSLATION: cfg_q.translation <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      kvt_pkg::REG_NODE_ROW_0:  prdata = cfg_q.node_row[0];
      kvt_pkg::REG_NODE_ROW_1:  prdata = cfg_q.node_row[1];
      kvt_pkg::REG_NODE_ROW_2:  prdata = cfg_q.node_row[2];
      kvt_pkg::REG_ROTATION:    prdata = cfg_q.rotation;
      kvt_pkg::REG_SCALE:       prdata = 64'(cfg_q.scale);
      kvt_pkg::REG_TRANSLATION: prdata = 64'(cfg_q.translation);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/kvt_rotmat.sv =====
// Rotation matrix of the keyframe quaternion, registered in Q4.12.
module kvt_rotmat (
  input  logic          clk_i,
  input  logic [63:0]   rotation_i,
  output kvt_pkg::rot_t rot_o
);

  localparam logic signed [63:0] One = 64'sd16777216;

  logic signed [15:0] w, x, y, z;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  kvt_pkg::rot_t      rot_q;

  assign w = $signed(rotation_i[15:0]);
  assign x = $signed(rotation_i[31:16]);
  assign y = $signed(rotation_i[47:32]);
  assign z = $signed(rotation_i[63:48]);

  assign xx = x * x;
  assign yy = y * y;
  assign zz = z * z;
  assign xy = x * y;
  assign xz = x * z;
  assign yz = y * z;
  assign xw = x * w;
  assign yw = y * w;
  assign zw = z * w;

  function automatic logic [kvt_pkg::Q_WIDTH-1:0] qent(input logic signed [63:0] v);
    return kvt_pkg::sat_q(kvt_pkg::rnd_shr(v));
  endfunction

  // Entries are Q8.24 sums, rounded and saturated back to Q4.12
  always_ff @(posedge clk_i) begin
    rot_q[0][0] <= qent(One - ((64'(yy) + 64'(zz)) <<< 1));
    rot_q[0][1] <= qent((64'(xy) - 64'(zw)) <<< 1);
    rot_q[0][2] <= qent((64'(xz) + 64'(yw)) <<< 1);
    rot_q[1][0] <= qent((64'(xy) + 64'(zw)) <<< 1);
    rot_q[1][1] <= qent(One - ((64'(xx) + 64'(zz)) <<< 1));
    rot_q[1][2] <= qent((64'(yz) - 64'(xw)) <<< 1);
    rot_q[2][0] <= qent((64'(xz) - 64'(yw)) <<< 1);
    rot_q[2][1] <= qent((64'(yz) + 64'(xw)) <<< 1);
    rot_q[2][2] <= qent(One - ((64'(xx) + 64'(yy)) <<< 1));
  end

  assign rot_o = rot_q;

endmodule

// ===== src/kvt_lane.sv =====
// One vector lane: scale, rotate, node matrix and keyframe translation.
module kvt_lane (
  input  logic                                clk_i,
  input  logic [kvt_pkg::LANE_STAGES-1:0]     en_i,
  input  kvt_pkg::vec_t                       vec_i,
  input  kvt_pkg::cfg_t                       cfg_i,
  input  kvt_pkg::rot_t                       rot_i,
  output kvt_pkg::lane_out_t                  res_o
);

  localparam int CW = kvt_pkg::COORD_WIDTH;
  localparam int AW = kvt_pkg::SCALED_W;
  localparam int BW = kvt_pkg::ROT_W;
  localparam int NW = kvt_pkg::NODE_W;

  logic signed [CW+15:0] sp_q [3];
  logic signed [AW-1:0]  a_q  [3];
  logic signed [AW+15:0] rp_q [3][3];
  logic signed [BW-1:0]  b_q  [3];
  logic signed [BW+15:0] np_q [3][3];
  logic signed [NW-1:0]  c1_q [3];
  logic signed [NW-1:0]  c2_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      // scale product, then round
      if (en_i[0]) sp_q[i] <= $signed(vec_i[i]) * $signed(cfg_i.scale[16*i +: 16]);
      if (en_i[1]) a_q[i] <= AW'(kvt_pkg::rnd_shr(64'(sp_q[i])));
      // rotation
      for (int j = 0; j < 3; j++) begin
        if (en_i[2]) rp_q[i][j] <= $signed(rot_i[i][j]) * a_q[j];
      end
      if (en_i[3]) begin
        b_q[i] <= BW'(kvt_pkg::rnd_shr(64'(rp_q[i][0]) + 64'(rp_q[i][1]) + 64'(rp_q[i][2])));
      end
      // node matrix
      for (int j = 0; j < 3; j++) begin
        if (en_i[4]) np_q[i][j] <= $signed(cfg_i.node_row[i][16*j +: 16]) * b_q[j];
      end
      if (en_i[5]) begin
        c1_q[i] <= NW'(kvt_pkg::clamp_wide(
                     kvt_pkg::rnd_shr(64'(np_q[i][0]) + 64'(np_q[i][1]) + 64'(np_q[i][2]))
                     + 64'($signed(cfg_i.node_row[i][63:48]))));
      end
      // keyframe translation
      if (en_i[6]) begin
        c2_q[i] <= NW'(kvt_pkg::clamp_wide(
                     64'(c1_q[i]) + 64'($signed(cfg_i.translation[16*i +: 16]))));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) res_o[i] = c2_q[i];
  end

endmodule

// ===== src/kvt_merge.sv =====
// Output stage: axis remap and saturation of both lanes, uv flip.
module kvt_merge (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  kvt_pkg::lane_out_t                pos_i,
  input  kvt_pkg::lane_out_t                norm_i,
  input  logic [kvt_pkg::UV_WIDTH-1:0]      u_i,
  input  logic [kvt_pkg::UV_WIDTH-1:0]      v_i,
  output kvt_pkg::out_item_t                word_o
);

  kvt_pkg::out_item_t word_d, word_q;

  always_comb begin
    word_d.out_pos_x  = kvt_pkg::sat_coord(-64'($signed(pos_i[0])));
    word_d.out_pos_y  = kvt_pkg::sat_coord(64'($signed(pos_i[2])));
    word_d.out_pos_z  = kvt_pkg::sat_coord(64'($signed(pos_i[1])));
    word_d.out_norm_x = kvt_pkg::sat_coord(-64'($signed(norm_i[0])));
    word_d.out_norm_y = kvt_pkg::sat_coord(64'($signed(norm_i[2])));
    word_d.out_norm_z = kvt_pkg::sat_coord(64'($signed(norm_i[1])));
    word_d.out_u      = kvt_pkg::one_minus(u_i);
    word_d.out_v      = kvt_pkg::one_minus(v_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== src/keyframe_vertex_transform.sv =====
// Top level of the keyframe vertex transform pipeline.
//
//   channel | direction | handshake                    | payload
//   --------+-----------+------------------------------+---------------------
//   in      | sink      | in_valid_i / in_stall_o      | in_word_i  (in_item_t)
//   out     | source    | out_valid_o / out_stall_i    | out_word_o (out_item_t)
//   config  | sink      | psel/penable/pwrite, pready  | paddr/pwdata/prdata
//
// Throughput is one word per cycle while out_stall_i is low; out_valid_o
// rises as a word enters the output register. The depth is set by the
// seven lane stages (product and sum stages for scale, rotation and node
// matrix, plus translation) and the output register.
// Position and normal run in two identical lanes; the merge stage remaps axes.
// Each stage loads when it is empty or the one after it is moving, so
// bubbles close up and a stalled output still lets earlier stages fill.
// Reset clears stage valids and loads the identity configuration.
// The rotation matrix is re-registered every cycle from the quaternion.
module keyframe_vertex_transform (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  kvt_pkg::in_item_t          in_word_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output kvt_pkg::out_item_t         out_word_o,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kvt_pkg::ADDR_W-1:0] paddr,
  input  logic [kvt_pkg::DATA_W-1:0] pwdata,
  output logic [kvt_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int NS = kvt_pkg::NUM_STAGES;
  localparam int LS = kvt_pkg::LANE_STAGES;

  kvt_pkg::cfg_t      cfg;
  kvt_pkg::rot_t      rot;
  kvt_pkg::vec_t      pos_vec, norm_vec;
  kvt_pkg::lane_out_t pos_res, norm_res;

  logic [NS-1:0] valid_q;
  logic [NS-1:0] en;

  // uv rides alongside the lanes untouched until the merge stage
  logic [kvt_pkg::UV_WIDTH-1:0] u_q [LS];
  logic [kvt_pkg::UV_WIDTH-1:0] v_q [LS];

  // ---------------------------------------------------------------------
  // Stage flow control: a stage loads when empty or when its successor
  // loads; the last stage drains on a non-stalled output.
  // ---------------------------------------------------------------------
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = valid_q[NS-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      u_q[0] <= in_word_i.tex_u;
      v_q[0] <= in_word_i.tex_v;
    end
    for (int k = 1; k < LS; k++) begin
      if (en[k]) begin
        u_q[k] <= u_q[k-1];
        v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration and rotation matrix
  // ---------------------------------------------------------------------
  kvt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kvt_rotmat u_rotmat (
    .clk_i      (clk_i),
    .rotation_i (cfg.rotation),
    .rot_o      (rot)
  );

  // ---------------------------------------------------------------------
  // Lanes: position and normal get the identical transform
  // ---------------------------------------------------------------------
  assign pos_vec[0]  = in_word_i.vertex_x;
  assign pos_vec[1]  = in_word_i.vertex_y;
  assign pos_vec[2]  = in_word_i.vertex_z;
  assign norm_vec[0] = in_word_i.normal_x;
  assign norm_vec[1] = in_word_i.normal_y;
  assign norm_vec[2] = in_word_i.normal_z;

  kvt_lane u_lane_pos (
    .clk_i (clk_i),
    .en_i  (en[LS-1:0]),
    .vec_i (pos_vec),
    .cfg_i (cfg),
    .rot_i (rot),
    .res_o (pos_res)
  );

  kvt_lane u_lane_norm (
    .clk_i (clk_i),
    .en_i  (en[LS-1:0]),
    .vec_i (norm_vec),
    .cfg_i (cfg),
    .rot_i (rot),
    .res_o (norm_res)
  );

  // ---------------------------------------------------------------------
  // Merge: negate x, swap y/z, saturate, flip uv into the output register
  // ---------------------------------------------------------------------
  kvt_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en[NS-1]),
    .pos_i  (pos_res),
    .norm_i (norm_res),
    .u_i    (u_q[LS-1]),
    .v_i    (v_q[LS-1]),
    .word_o (out_word_o)
  );

endmodule
